// File: sv/cbv_pkg.sv
// Package for the chunk box visibility table: table size, operation codes and
// the shared types for a table entry and the scan pipeline flags. No dependencies.
`default_nettype none

package cbv_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef logic [IDX_W-1:0] idx_t;

    // One table entry: chunk tag and the inclusive integer box bounds.
    typedef struct packed {
        logic signed [31:0] tag;
        logic signed [31:0] min_x;
        logic signed [31:0] min_y;
        logic signed [31:0] min_z;
        logic signed [31:0] max_x;
        logic signed [31:0] max_y;
        logic signed [31:0] max_z;
    } entry_t;

    // Flags that travel with an entry through the scan pipeline.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } probe_t;

    // Registered outcome of testing one entry.
    typedef struct packed {
        logic valid;
        logic last;
        logic hit;
    } match_t;

endpackage

`default_nettype wire

// File: sv/cbv_table.sv
// Entry memory of the chunk box visibility table with one write and one
// registered read port, plus per-entry valid bits. Depends on cbv_pkg.
`default_nettype none

module cbv_table
    import cbv_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   we,
    input  idx_t   waddr,
    input  entry_t wdata,
    input  logic   clear,
    input  logic   re,
    input  idx_t   raddr,
    output entry_t rdata
);

    entry_t             mem [ENTRIES];
    entry_t             mem_q_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic               rd_ok_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            mem_q_reg <= mem[raddr];
        end
    end

    // Valid bits stand in for clearing the memory: an entry never written since
    // reset or the last clear reads as all zeros.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                valid_reg <= '0;
            end
            else if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rd_ok_reg <= valid_reg[raddr];
            end
        end
    end

    assign rdata = rd_ok_reg ? mem_q_reg : '0;

`ifndef NO_ASSERTIONS
    a_no_write_during_scan: assert property (@(posedge clk) disable iff (!rst_n)
        !(we && re))
        else $error("table written while a scan is reading it");
    a_no_clear_during_scan: assert property (@(posedge clk) disable iff (!rst_n)
        !(clear && re))
        else $error("table cleared while a scan is reading it");
    a_single_update: assert property (@(posedge clk) disable iff (!rst_n)
        !(clear && we))
        else $error("clear and write in the same cycle");
`endif

endmodule

`default_nettype wire

// File: sv/cbv_match.sv
// Tests one entry read from the table against the query tag and position and
// registers the outcome. Depends on cbv_pkg.
`default_nettype none

module cbv_match
    import cbv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  probe_t             probe,
    input  entry_t             entry,
    input  logic signed [31:0] id,
    input  logic signed [47:0] pos_x,
    input  logic signed [47:0] pos_y,
    input  logic signed [47:0] pos_z,
    output match_t             result
);

    match_t match_reg;
    match_t match_next;
    logic   in_box;
    logic   empty_table;

    // Bounds are integers; shifting them left by 16 puts them on the position's
    // fixed point grid exactly, and the product always fits in 48 bits.
    always_comb
    begin
        in_box = (pos_x >= $signed({entry.min_x, 16'h0000}))
              && (pos_x <= $signed({entry.max_x, 16'h0000}))
              && (pos_y >= $signed({entry.min_y, 16'h0000}))
              && (pos_y <= $signed({entry.max_y, 16'h0000}))
              && (pos_z >= $signed({entry.min_z, 16'h0000}))
              && (pos_z <= $signed({entry.max_z, 16'h0000}));
        // A zero tag in entry 0 means no table is loaded.
        empty_table      = probe.first && (entry.tag == 32'sd0);
        match_next.valid = probe.valid;
        match_next.last  = probe.valid && probe.last;
        match_next.hit   = probe.valid && (empty_table || ((entry.tag == id) && in_box));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= '0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    assign result = match_reg;

endmodule

`default_nettype wire

// File: sv/chunk_box_visibility_table_core.sv
// Top level of the chunk box visibility table: command decode, scan sequencer
// and result register. Depends on cbv_pkg, cbv_table and cbv_match.
`default_nettype none

// A word is accepted on a rising edge with start high and busy low. A write
// (op 0) stores one tagged box at entry_index and a clear (op 2) empties the
// whole table; both finish in the accepting cycle, so busy stays low and the
// next word may follow at once. Op 3 and writes to a slot at or beyond ENTRIES
// are ignored. A query (op 1) raises busy and scans the table one entry per
// cycle through the single read port of the entry memory. Its result goes
// through a registered read of each entry in turn, the registered box test on
// the last entry's data, which shows in the cycle after its read, and the
// result register. The answer appears on visible with done high for exactly
// one cycle; the receiver cannot stall it, and since busy drops at the same
// edge, a new word may be accepted at the edge that ends the result cycle.
// visible is 1 when entry 0 holds tag 0 (no table loaded), or when some entry
// carries the queried chunk_id and the position, signed fixed point with 16
// fraction bits, lies inside its box with every integer bound inclusive.
// Reset and clear make every entry read as zeros.

module chunk_box_visibility_table_core
    import cbv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         op,
    input  logic [5:0]         entry_index,
    input  logic signed [31:0] chunk_id,
    input  logic signed [31:0] min_x,
    input  logic signed [31:0] min_y,
    input  logic signed [31:0] min_z,
    input  logic signed [31:0] max_x,
    input  logic signed [31:0] max_y,
    input  logic signed [31:0] max_z,
    input  logic signed [47:0] pos_x,
    input  logic signed [47:0] pos_y,
    input  logic signed [47:0] pos_z,
    output logic               done,
    output logic               visible
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    idx_t               scan_reg;
    idx_t               scan_next;
    logic               found_reg;
    logic               found_next;
    logic               done_reg;
    logic               done_next;
    logic               visible_reg;
    logic               visible_next;
    probe_t             probe_reg;
    probe_t             probe_next;

    logic signed [31:0] id_reg;
    logic signed [47:0] px_reg;
    logic signed [47:0] py_reg;
    logic signed [47:0] pz_reg;

    logic               accept;
    logic               slot_ok;
    logic               we;
    logic               clear;
    logic               re;
    entry_t             wdata;
    entry_t             rdata;
    match_t             match;

    assign accept  = start && !busy;
    // Only slots below ENTRIES exist; compared wide so any table size works.
    assign slot_ok = {26'd0, entry_index} < 32'(ENTRIES);
    assign we      = accept && (op == OP_WRITE) && slot_ok;
    assign clear   = accept && (op == OP_CLEAR);
    assign re      = (state_reg == ST_SCAN);
    assign busy    = (state_reg != ST_IDLE);

    always_comb
    begin
        wdata.tag   = chunk_id;
        wdata.min_x = min_x;
        wdata.min_y = min_y;
        wdata.min_z = min_z;
        wdata.max_x = max_x;
        wdata.max_y = max_y;
        wdata.max_z = max_z;
    end

    cbv_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (we),
        .waddr (idx_t'(entry_index)),
        .wdata (wdata),
        .clear (clear),
        .re    (re),
        .raddr (scan_reg),
        .rdata (rdata)
    );

    cbv_match u_match (
        .clk    (clk),
        .rst_n  (rst_n),
        .probe  (probe_reg),
        .entry  (rdata),
        .id     (id_reg),
        .pos_x  (px_reg),
        .pos_y  (py_reg),
        .pos_z  (pz_reg),
        .result (match)
    );

    // Sequencer: issue one read per cycle in SCAN, then wait for the last
    // entry's test to come out of the match stage.
    always_comb
    begin
        state_next   = state_reg;
        scan_next    = scan_reg;
        found_next   = found_reg;
        done_next    = 1'b0;
        visible_next = visible_reg;

        // Flags for the entry being read this cycle; they line up with its data.
        probe_next.valid = re;
        probe_next.first = re && (scan_reg == idx_t'(0));
        probe_next.last  = re && (scan_reg == idx_t'(ENTRIES - 1));

        if (match.valid)
        begin
            found_next = found_reg || match.hit;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (op == OP_QUERY))
                begin
                    state_next = ST_SCAN;
                    scan_next  = idx_t'(0);
                    found_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                scan_next = scan_reg + idx_t'(1);
                if (scan_reg == idx_t'(ENTRIES - 1))
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (match.valid && match.last)
                begin
                    state_next   = ST_IDLE;
                    done_next    = 1'b1;
                    visible_next = found_reg || match.hit;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            scan_reg    <= '0;
            found_reg   <= 1'b0;
            done_reg    <= 1'b0;
            visible_reg <= 1'b0;
            probe_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            scan_reg    <= scan_next;
            found_reg   <= found_next;
            done_reg    <= done_next;
            visible_reg <= visible_next;
            probe_reg   <= probe_next;
        end
    end

    // Query operands are held for the whole scan.
    always_ff @(posedge clk)
    begin
        if (accept && (op == OP_QUERY))
        begin
            id_reg <= chunk_id;
            px_reg <= pos_x;
            py_reg <= pos_y;
            pz_reg <= pos_z;
        end
    end

    assign done    = done_reg;
    assign visible = visible_reg;

`ifndef NO_ASSERTIONS
    a_done_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_WAIT))
        else $error("result strobe without a finished scan");
    a_match_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        match.valid |-> busy)
        else $error("entry test outcome arrived outside a query");
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("more than one result for a query");
    a_read_in_scan_only: assert property (@(posedge clk) disable iff (!rst_n)
        probe_reg.valid |-> (state_reg == ST_SCAN || state_reg == ST_WAIT))
        else $error("table read outside a scan");
`endif

endmodule

`default_nettype wire
